/* sv/bom_utf16_or_cp1252_text_decoder_defines.svh */
// Assertion helpers shared by the decoder files.
// Each macro expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef BOM_UTF16_OR_CP1252_TEXT_DECODER_DEFINES_SVH
`define BOM_UTF16_OR_CP1252_TEXT_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BOMDEC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BOMDEC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/bomdec_pkg.sv */
package bomdec_pkg;

    // One input word: a raw string byte and its end flag.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    // One result word.
    typedef struct packed {
        logic [20:0] code_point;
        logic        has_char;
        logic        run_last;
        logic        string_end;
    } out_word_t;

    // Decoder to result queue: up to two results per byte.
    typedef struct packed {
        logic [1:0] count;
        out_word_t  res0;
        out_word_t  res1;
    } push_t;

    // Result queue status seen by the decoder.
    typedef struct packed {
        logic room;
    } queue_stat_t;

    // Result queue depth: a power of two, at least two so one byte's results always fit.
    localparam int ResDepth = 4;

    localparam logic [7:0]  BomFirst  = 8'hFE;
    localparam logic [7:0]  BomSecond = 8'hFF;
    localparam logic [5:0]  HiSurTag  = 6'b110110;  // units D800-DBFF
    localparam logic [5:0]  LoSurTag  = 6'b110111;  // units DC00-DFFF
    localparam logic [20:0] SupBase   = 21'h10000;
    localparam logic [2:0]  CtlRowTag = 3'b100;     // bytes 80-9F

    // Windows-1252 code points for bytes 80 through 9F.
    localparam logic [15:0] W1252Hi [32] = '{
        16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
        16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
    };

    // Map one byte through Windows-1252.
    function automatic logic [20:0] map_cp1252(input logic [7:0] b);
        logic [15:0] cp;
        if (b[7:5] == CtlRowTag) begin
            cp = W1252Hi[b[4:0]];
        end else begin
            cp = {8'h00, b};
        end
        return {5'b0, cp};
    endfunction

endpackage

/* sv/bom_utf16_or_cp1252_text_decoder.sv */
// Decodes a text string one byte per word: a string that opens with FE FF is read as
// big-endian UTF-16 (surrogate pairs merged, lone surrogates and an odd final byte
// dropped), any other string maps every byte through Windows-1252. The decoder takes
// one byte per clock while the result queue has room. Each byte gives zero, one or two
// result words; an accepted byte waits in the input register until the queue has room
// for two words, then its results enter a four-word result queue and leave it one per
// clock while the output is ready. With the output ready every clock the input never
// stalls, since a byte that releases two words always follows one that gave none; while
// the output is held off, the input stalls as soon as fewer than two queue words are
// free. The last byte of a string always yields a word with string_end set; a string
// that ends without a character yields a bare end word with has_char clear.
`include "bom_utf16_or_cp1252_text_decoder_defines.svh"

module bom_utf16_or_cp1252_text_decoder #(
    parameter int ResDepth = bomdec_pkg::ResDepth
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  bomdec_pkg::in_word_t  s_word,
    output logic                  m_valid,
    input  logic                  m_ready,
    output bomdec_pkg::out_word_t m_word
);
    import bomdec_pkg::*;

    push_t       push;
    queue_stat_t stat;

    // Input register, string state and per-byte decode.
    bomdec_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .stat    (stat),
        .push    (push)
    );

    // Result queue toward the output channel.
    bomdec_res_queue #(
        .Depth (ResDepth)
    ) u_res_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    `BOMDEC_ASSERT_NOW(a_push_fits, push.count != 2'd0, stat.room, "push without room")
    `BOMDEC_ASSERT_NOW(a_end_is_run_last, m_valid && m_word.string_end, m_word.run_last,
        "string end is not the last result of its byte")
    `BOMDEC_ASSERT_NOW(a_bare_end, m_valid && !m_word.has_char,
        m_word.string_end && m_word.code_point == 21'd0, "bare word is not an end marker")
    `BOMDEC_ASSERT_NEXT(a_push_shows, push.count != 2'd0, m_valid,
        "pushed result not visible")

endmodule

/* sv/bomdec_decode.sv */
module bomdec_decode (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  bomdec_pkg::in_word_t   s_word,
    input  bomdec_pkg::queue_stat_t stat,
    output bomdec_pkg::push_t      push
);
    import bomdec_pkg::*;

    typedef enum logic [2:0] {
        PH_FIRST  = 3'd0,
        PH_HOLD   = 3'd1,
        PH_U16_HI = 3'd2,
        PH_U16_LO = 3'd3,
        PH_CP1252 = 3'd4
    } phase_t;

    logic      in_valid_reg;
    in_word_t  in_word_reg;
    phase_t    phase_reg, phase_next;
    logic [7:0] held_first_reg, held_first_next;
    logic [7:0] held_high_reg, held_high_next;
    logic [9:0] pend_bits_reg, pend_bits_next;
    logic       pend_valid_reg, pend_valid_next;

    logic       advance;
    logic [7:0] b;
    logic       last;
    logic [15:0] unit;
    logic       is_hi;
    logic       is_lo;
    logic [1:0] n;
    out_word_t  r0;
    out_word_t  r1;

    // The input word advances whenever the result queue can take two more words.
    assign advance = in_valid_reg && stat.room;
    assign s_ready = !in_valid_reg || advance;

    assign b     = in_word_reg.data_byte;
    assign last  = in_word_reg.last_byte;
    assign unit  = {held_high_reg, b};
    assign is_hi = (unit[15:10] == HiSurTag);
    assign is_lo = (unit[15:10] == LoSurTag);

    // Decode one byte against the current string state.
    always_comb begin
        phase_next      = phase_reg;
        held_first_next = held_first_reg;
        held_high_next  = held_high_reg;
        pend_bits_next  = pend_bits_reg;
        pend_valid_next = pend_valid_reg;
        n  = 2'd0;
        r0 = '0;
        r1 = '0;

        unique case (phase_reg)
            PH_HOLD: begin
                if (held_first_reg == BomFirst && b == BomSecond) begin
                    if (last) begin
                        n = 2'd1;
                        r0.string_end = 1'b1;
                    end else begin
                        phase_next = PH_U16_HI;
                    end
                end else begin
                    n = 2'd2;
                    r0.code_point = map_cp1252(held_first_reg);
                    r0.has_char   = 1'b1;
                    r1.code_point = map_cp1252(b);
                    r1.has_char   = 1'b1;
                    r1.string_end = last;
                    phase_next    = PH_CP1252;
                end
            end
            PH_U16_HI: begin
                if (last) begin
                    n = 2'd1;
                    r0.string_end = 1'b1;
                end else begin
                    held_high_next = b;
                    phase_next     = PH_U16_LO;
                end
            end
            PH_U16_LO: begin
                pend_valid_next = 1'b0;
                pend_bits_next  = '0;
                if (pend_valid_reg && is_lo) begin
                    n = 2'd1;
                    r0.code_point = SupBase + {1'b0, pend_bits_reg, unit[9:0]};
                    r0.has_char   = 1'b1;
                    r0.string_end = last;
                end else if (is_hi) begin
                    pend_valid_next = 1'b1;
                    pend_bits_next  = unit[9:0];
                    if (last) begin
                        n = 2'd1;
                        r0.string_end = 1'b1;
                    end
                end else if (!is_lo) begin
                    n = 2'd1;
                    r0.code_point = {5'b0, unit};
                    r0.has_char   = 1'b1;
                    r0.string_end = last;
                end else if (last) begin
                    n = 2'd1;
                    r0.string_end = 1'b1;
                end
                phase_next = PH_U16_HI;
            end
            PH_CP1252: begin
                n = 2'd1;
                r0.code_point = map_cp1252(b);
                r0.has_char   = 1'b1;
                r0.string_end = last;
            end
            default: begin
                if (last) begin
                    n = 2'd1;
                    r0.code_point = map_cp1252(b);
                    r0.has_char   = 1'b1;
                    r0.string_end = 1'b1;
                end else begin
                    held_first_next = b;
                    phase_next      = PH_HOLD;
                end
            end
        endcase

        // The end of a string returns every state field to its reset value.
        if (last) begin
            phase_next      = PH_FIRST;
            held_first_next = '0;
            held_high_next  = '0;
            pend_bits_next  = '0;
            pend_valid_next = 1'b0;
        end

        // Mark the final result of this byte.
        r0.run_last = (n == 2'd1);
        r1.run_last = 1'b1;
    end

    assign push.count = advance ? n : 2'd0;
    assign push.res0  = r0;
    assign push.res1  = r1;

    // Input word register and string state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            in_word_reg    <= '0;
            phase_reg      <= PH_FIRST;
            held_first_reg <= '0;
            held_high_reg  <= '0;
            pend_bits_reg  <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
                in_word_reg  <= s_word;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                phase_reg      <= phase_next;
                held_first_reg <= held_first_next;
                held_high_reg  <= held_high_next;
                pend_bits_reg  <= pend_bits_next;
                pend_valid_reg <= pend_valid_next;
            end
        end
    end

endmodule

/* sv/bomdec_res_queue.sv */
module bomdec_res_queue #(
    parameter int Depth = bomdec_pkg::ResDepth
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  bomdec_pkg::push_t       push,
    output bomdec_pkg::queue_stat_t stat,
    output logic                    m_valid,
    input  logic                    m_ready,
    output bomdec_pkg::out_word_t   m_word
);
    import bomdec_pkg::*;

    localparam int PtrW  = $clog2(Depth);
    localparam int FillW = $clog2(Depth + 1);

    out_word_t        mem_reg [Depth];
    logic [PtrW-1:0]  wr_ptr_reg;
    logic [PtrW-1:0]  rd_ptr_reg;
    logic [FillW-1:0] fill_reg, fill_next;
    logic             pop;
    logic [PtrW-1:0]  wr_ptr_plus1;

    assign pop          = m_valid && m_ready;
    assign m_valid      = (fill_reg != '0);
    assign m_word       = mem_reg[rd_ptr_reg];
    assign wr_ptr_plus1 = wr_ptr_reg + PtrW'(1);

    // Room for a full two-word push, judged from the stored fill alone.
    assign stat.room  = (fill_reg <= FillW'(Depth - 2));

    assign fill_next = fill_reg + FillW'(push.count) - FillW'(pop);

    // Result storage: up to two words written, one read, per cycle.
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_ptr_plus1] <= push.res1;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PtrW'(push.count);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            end
            fill_reg <= fill_next;
        end
    end

endmodule
